FILE: rtl/core/sri_pkg.sv
// Package for the stepper ramp interval generator.
// Holds field widths, register indexes, reset values and the controller/datapath structs.
// No dependencies.
package sri_pkg;

	localparam int DIST_W    = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_START_INTERVAL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] START_INTERVAL_RESET = CFG_W'(39028);
	localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET   = CFG_W'(1000);

	// Input item and configuration write payloads.
	typedef struct packed {
		logic signed [DIST_W-1:0] distance_to_go;
	} req_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     wdata;
	} cfg_wr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted distance
		logic adjust;     // work out the adjusted ramp counter
		logic div_start;  // set up the divider
		logic div_step;   // one restoring division step
		logic commit;     // update state and the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dist_zero;
		logic n_zero;
	} dp_status_t;

endpackage

FILE: rtl/core/sri_stream_if.sv
// Valid/ready channel interface with a typed payload.
// Depends on nothing; payload types come from sri_pkg or the top level.
interface sri_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/stepper_ramp_interval_generator.sv
// Top level of the stepper ramp interval generator.
// Joins sri_controller and sri_datapath; channels are sri_stream_if instances, types from sri_pkg.
//
// Usage. One distance-to-target transfer arrives on req per step event and gives exactly
// one transfer on rsp: the interval in microseconds until the next step (0 when the target
// is reached) and the travel direction. The cfg channel writes start_interval (index 0) and
// min_interval (index 1); always ready. The user makes writes while the block is idle; nothing enforces it.
//
// Timing. A distance is taken when req.ready is high, which is whenever no item is in work.
// An item that needs a division passes through the adjust state, the divider set-up state,
// INTERVAL_BITS + 1 steps of the bit-serial restoring divider and the commit state, which
// waits for the output register to be free, before its result appears on rsp. At target
// or on the first step from rest no division is done; set-up goes straight to commit.
// The next distance is taken only after the previous item has been committed.
//
// The result waits in an output register; a new distance may be taken while it waits, but
// the commit of that item holds until rsp has been transferred. After reset the ramp counter,
// interval and direction are zero and the registers hold their default values.
module stepper_ramp_interval_generator #(
	parameter int INTERVAL_BITS = 24,
	parameter int COUNT_BITS    = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sri_stream_if.sink   req,
	sri_stream_if.sink   cfg,
	sri_stream_if.source rsp
);
	import sri_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The configuration port never stalls.
	assign cfg.ready = 1'b1;

	sri_controller #(
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sri_datapath #(
		.INTERVAL_BITS (INTERVAL_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.distance_to_go (req.data.distance_to_go),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.data.index),
		.cfg_wdata      (cfg.data.wdata),
		.step_interval  (rsp.data.step_interval),
		.direction      (rsp.data.direction)
	);

endmodule

FILE: rtl/core/sri_datapath.sv
// Datapath of the stepper ramp interval generator: configuration registers, ramp state,
// direction logic, serial restoring divider and output payload register. Uses sri_pkg.
module sri_datapath #(
	parameter int INTERVAL_BITS = 24,
	parameter int COUNT_BITS    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sri_pkg::dp_cmd_t                    cmd,
	output sri_pkg::dp_status_t                 status,
	input  logic signed [sri_pkg::DIST_W-1:0]   distance_to_go,
	input  logic                                cfg_we,
	input  logic [sri_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sri_pkg::CFG_W-1:0]           cfg_wdata,
	output logic [INTERVAL_BITS-1:0]            step_interval,
	output logic                                direction
);
	import sri_pkg::*;

	localparam int IB = INTERVAL_BITS;
	localparam int CB = COUNT_BITS;
	localparam logic [IB-1:0] IVAL_MAX = {IB{1'b1}};
	localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};

	// Configuration values are masked to the interval width.
	function automatic logic [IB-1:0] fit_interval(input logic [CFG_W-1:0] v);
		logic [CFG_W+IB-1:0] ext;
		ext = {{IB{1'b0}}, v};
		return ext[IB-1:0];
	endfunction

	logic [IB-1:0]            start_interval_q;
	logic [IB-1:0]            min_interval_q;
	logic signed [CB-1:0]     ramp_count_q;
	logic [IB-1:0]            current_interval_q;
	logic                     travel_dir_q;
	logic signed [DIST_W-1:0] dist_q;
	logic signed [CB-1:0]     n_adj_q;
	logic [CB:0]              div_q;
	logic [CB:0]              rem_q;
	logic [IB:0]              quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_interval_q <= fit_interval(START_INTERVAL_RESET);
			min_interval_q   <= fit_interval(MIN_INTERVAL_RESET);
		end else if (cfg_we) begin
			if (cfg_index == REG_START_INTERVAL) begin
				start_interval_q <= fit_interval(cfg_wdata);
			end else if (cfg_index == REG_MIN_INTERVAL) begin
				min_interval_q <= fit_interval(cfg_wdata);
			end
		end
	end

	// Direction decision: stop_steps against the distance magnitude.
	logic                 dist_pos;
	logic [CB-1:0]        stop_steps;
	logic [32:0]          stop_ext;
	logic [32:0]          mag;
	logic                 stop_ge;
	logic                 dir_match;
	logic                 flip;

	always_comb begin
		dist_pos   = !dist_q[DIST_W-1] && (dist_q != '0);
		stop_steps = ramp_count_q[CB-1] ? CB'(-ramp_count_q) : CB'(ramp_count_q);
		stop_ext   = 33'(stop_steps);
		mag        = dist_q[DIST_W-1] ? 33'(-{dist_q[DIST_W-1], dist_q})
		                              : 33'({1'b0, dist_q});
		stop_ge    = stop_ext >= mag;
		dir_match  = dist_pos ? travel_dir_q : !travel_dir_q;
		if (ramp_count_q == '0) begin
			flip = 1'b0;
		end else if (!ramp_count_q[CB-1]) begin
			flip = stop_ge || !dir_match;
		end else begin
			flip = !stop_ge && dir_match;
		end
	end

	// Divider set-up values and one restoring step.
	logic [CB-1:0] abs_n;
	logic [CB:0]   div_init;
	logic [CB+1:0] trial;
	logic [CB+1:0] diff;
	logic          take;

	always_comb begin
		abs_n    = n_adj_q[CB-1] ? CB'(-n_adj_q) : CB'(n_adj_q);
		div_init = n_adj_q[CB-1] ? ({abs_n[CB-2:0], 2'b00} - (CB+1)'(1))
		                         : {abs_n[CB-2:0], 2'b01};
		trial    = {rem_q, quo_q[IB]};
		diff     = trial - {1'b0, div_q};
		take     = trial >= {1'b0, div_q};
	end

	// Interval update from the quotient magnitude.
	logic [IB+1:0] c_sum;
	logic [IB-1:0] c_sat;
	logic [IB-1:0] c_new;

	always_comb begin
		if (n_adj_q[CB-1]) begin
			c_sum = {2'b00, current_interval_q} + {1'b0, quo_q};
		end else begin
			c_sum = {2'b00, current_interval_q} - {1'b0, quo_q};
		end
		c_sat = (c_sum > {2'b00, IVAL_MAX}) ? IVAL_MAX : c_sum[IB-1:0];
		c_new = (c_sat < min_interval_q) ? min_interval_q : c_sat;
	end

	assign status.dist_zero = (dist_q == '0);
	assign status.n_zero    = (n_adj_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_count_q       <= '0;
			current_interval_q <= '0;
			travel_dir_q       <= 1'b0;
		end else if (cmd.commit) begin
			if (dist_q == '0) begin
				ramp_count_q <= '0;
			end else begin
				ramp_count_q <= (n_adj_q == CNT_MAX) ? n_adj_q : n_adj_q + CB'(1);
				if (n_adj_q == '0) begin
					current_interval_q <= start_interval_q;
					travel_dir_q       <= dist_pos;
				end else begin
					current_interval_q <= c_new;
				end
			end
		end
	end

	// Working and output payload registers need no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q <= distance_to_go;
		end
		if (cmd.adjust) begin
			n_adj_q <= flip ? -ramp_count_q : ramp_count_q;
		end
		if (cmd.div_start) begin
			div_q <= div_init;
			rem_q <= '0;
			quo_q <= {current_interval_q, 1'b0};
		end else if (cmd.div_step) begin
			rem_q <= take ? diff[CB:0] : trial[CB:0];
			quo_q <= {quo_q[IB-1:0], take};
		end
		if (cmd.commit) begin
			if (dist_q == '0) begin
				step_interval <= '0;
				direction     <= travel_dir_q;
			end else if (n_adj_q == '0) begin
				step_interval <= start_interval_q;
				direction     <= dist_pos;
			end else begin
				step_interval <= c_new;
				direction     <= travel_dir_q;
			end
		end
	end

endmodule

FILE: rtl/core/sri_controller.sv
// Controller of the stepper ramp interval generator: sequences accept, adjust,
// divider set-up, division steps and commit. Uses sri_pkg.
module sri_controller #(
	parameter int INTERVAL_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sri_pkg::dp_status_t status,
	output sri_pkg::dp_cmd_t    cmd
);
	import sri_pkg::*;

	localparam int STEP_W = $clog2(INTERVAL_BITS + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(INTERVAL_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADJ,
		S_SETUP,
		S_DIV,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.adjust    = (state_q == S_ADJ);
		cmd.div_start = (state_q == S_SETUP);
		cmd.div_step  = (state_q == S_DIV);
		cmd.commit    = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// A commit in the same cycle refills the output register, so valid stays high.
			if (out_valid && out_ready && !cmd.commit) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					step_q <= '0;
					if (status.dist_zero || status.n_zero) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
